// ----- rtl/integer_field_formatter_unit_defines.svh -----
// Assertion macros for the formatter RTL (used by intfmt_emit).
`ifndef INTEGER_FIELD_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define INTFMT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define INTFMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/intfmt_pkg.sv -----
`timescale 1ns / 1ps
package intfmt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_WIDTH  = 64;

  // digit counts per base
  localparam int ND10 = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int ND8  = (VALUE_BITS + 2) / 3;
  localparam int ND16 = (VALUE_BITS + 3) / 4;
  localparam int ND2  = VALUE_BITS;

  // digit shift register: wide enough for every base, MSD at the top
  localparam int SR_A = 4 * ND10;
  localparam int SR_B = (3 * ND8 > SR_A) ? 3 * ND8 : SR_A;
  localparam int SR_C = (4 * ND16 > SR_B) ? 4 * ND16 : SR_B;
  localparam int SR_W = (ND2 > SR_C) ? ND2 : SR_C;

  localparam int LEN_W     = $clog2(ND2 + 1);
  localparam int W_W       = $clog2(MAX_WIDTH + 1);
  localparam int DAB_W     = $clog2(VALUE_BITS + 1);
  localparam int MAX_CHARS = (MAX_WIDTH > VALUE_BITS + 1) ? MAX_WIDTH : VALUE_BITS + 1;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_UPPER = 8'h41;

  typedef enum logic [2:0] {
    K_SDEC = 3'd0,
    K_UDEC = 3'd1,
    K_OCT  = 3'd2,
    K_HEXL = 3'd3,
    K_HEXU = 3'd4,
    K_BIN  = 3'd5,
    K_CHAR = 3'd6
  } kind_t;

  typedef struct packed {
    logic             done;
    logic             neg;
    logic             fill_zero;
    logic             left;
    logic [LEN_W-1:0] len;
    logic [W_W-1:0]   width;
    logic [7:0]       chr;
  } conv_status_t;

  typedef struct packed {
    logic advance;
    logic finish;
  } emit_ctl_t;

  function automatic logic [3:0] top_digit(logic [SR_W-1:0] s, kind_t k);
    logic [3:0] d;
    case (k)
      K_OCT:   d = {1'b0, s[SR_W-1 -: 3]};
      K_BIN:   d = {3'b000, s[SR_W-1]};
      default: d = s[SR_W-1 -: 4];
    endcase
    return d;
  endfunction

  function automatic logic [SR_W-1:0] shift_digit(logic [SR_W-1:0] s, kind_t k);
    logic [SR_W-1:0] r;
    case (k)
      K_OCT:   r = s << 3;
      K_BIN:   r = s << 1;
      default: r = s << 4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_ascii(logic [3:0] d, logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'h0, d};
    end else begin
      c = (upper ? CH_UPPER : CH_LOWER) + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- rtl/intfmt_conv.sv -----
`timescale 1ns / 1ps
module intfmt_conv (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  logic [2:0]               req_type,
  input  logic [31:0]              value,
  input  logic [6:0]               min_width,
  input  logic                     left_justify,
  input  logic                     zero_fill,
  output logic                     busy,
  input  intfmt_pkg::emit_ctl_t    ctl,
  output intfmt_pkg::conv_status_t st
);
  import intfmt_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE   = 4'b0001,
    C_DABBLE = 4'b0010,
    C_SKIP   = 4'b0100,
    C_READY  = 4'b1000
  } cstate_t;

  cstate_t             state, state_next;
  kind_t               kind, kind_next;
  logic [SR_W-1:0]     sr, sr_next;
  logic [VALUE_BITS-1:0] bin, bin_next;
  logic [DAB_W-1:0]    cnt, cnt_next;
  logic [LEN_W-1:0]    len, len_next;
  logic [W_W-1:0]      width, width_next;
  logic                neg, neg_next;
  logic                fzero, fzero_next;
  logic                left, left_next;
  logic [7:0]          cbyte, cbyte_next;

  logic [VALUE_BITS-1:0] v, mag;
  kind_t                 kind_in;
  logic [W_W-1:0]        wsat;
  logic [SR_W-1:0]       adj, dab_sr;
  logic [3:0]            d;
  logic [3:0]            top;

  assign busy = (state != C_IDLE);
  assign top  = top_digit(sr, kind);

  // double-dabble step: +3 on digits of 5 and up, then shift a binary bit in
  always_comb begin
    adj = sr;
    for (int i = 0; i < ND10; i++) begin
      d = sr[SR_W-4*i-1 -: 4];
      if (d >= 4'd5) begin
        adj[SR_W-4*i-1 -: 4] = d + 4'd3;
      end
    end
    dab_sr = (adj << 1) | (SR_W'(bin[VALUE_BITS-1]) << (SR_W - 4*ND10));
  end

  always_comb begin
    v       = VALUE_BITS'(value);
    kind_in = kind_t'(req_type);
    mag     = (kind_in == K_SDEC && v[VALUE_BITS-1]) ? (~v + 1'b1) : v;
    wsat    = (int'(min_width) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(min_width);

    state_next = state;
    kind_next  = kind;
    sr_next    = sr;
    bin_next   = bin;
    cnt_next   = cnt;
    len_next   = len;
    width_next = width;
    neg_next   = neg;
    fzero_next = fzero;
    left_next  = left;
    cbyte_next = cbyte;

    case (state)
      C_IDLE: begin
        if (req_valid) begin
          kind_next  = kind_in;
          width_next = wsat;
          left_next  = left_justify;
          fzero_next = zero_fill && !left_justify && (kind_in != K_CHAR);
          neg_next   = 1'b0;
          cbyte_next = value[7:0];
          case (kind_in)
            K_SDEC, K_UDEC: begin
              bin_next   = mag;
              sr_next    = '0;
              cnt_next   = DAB_W'(VALUE_BITS);
              neg_next   = (kind_in == K_SDEC) && v[VALUE_BITS-1];
              state_next = C_DABBLE;
            end
            K_OCT: begin
              sr_next    = SR_W'(mag) << (SR_W - 3*ND8);
              len_next   = LEN_W'(ND8);
              state_next = C_SKIP;
            end
            K_HEXL, K_HEXU: begin
              sr_next    = SR_W'(mag) << (SR_W - 4*ND16);
              len_next   = LEN_W'(ND16);
              state_next = C_SKIP;
            end
            K_BIN: begin
              sr_next    = SR_W'(mag) << (SR_W - ND2);
              len_next   = LEN_W'(ND2);
              state_next = C_SKIP;
            end
            K_CHAR: begin
              len_next   = (value[7:0] != 8'h00) ? LEN_W'(1) : '0;
              state_next = C_READY;
            end
            default: ;  // unknown conversion: dropped
          endcase
        end
      end
      C_DABBLE: begin
        sr_next  = dab_sr;
        bin_next = bin << 1;
        cnt_next = cnt - 1'b1;
        if (cnt == DAB_W'(1)) begin
          len_next   = LEN_W'(ND10);
          state_next = C_SKIP;
        end
      end
      C_SKIP: begin
        if (top == 4'h0 && len > LEN_W'(1)) begin
          sr_next  = shift_digit(sr, kind);
          len_next = len - 1'b1;
        end else begin
          state_next = C_READY;
        end
      end
      C_READY: begin
        if (ctl.advance) begin
          sr_next = shift_digit(sr, kind);
        end
        if (ctl.finish) begin
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      cnt   <= '0;
      len   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    kind  <= kind_next;
    sr    <= sr_next;
    bin   <= bin_next;
    width <= width_next;
    neg   <= neg_next;
    fzero <= fzero_next;
    left  <= left_next;
    cbyte <= cbyte_next;
  end

  always_comb begin
    st.done      = (state == C_READY);
    st.neg       = neg;
    st.fill_zero = fzero;
    st.left      = left;
    st.len       = len;
    st.width     = width;
    st.chr       = (kind == K_CHAR) ? cbyte : to_ascii(top, kind == K_HEXU);
  end

endmodule

// ----- rtl/intfmt_emit.sv -----
`timescale 1ns / 1ps
`include "integer_field_formatter_unit_defines.svh"
module intfmt_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  intfmt_pkg::conv_status_t st,
  output intfmt_pkg::emit_ctl_t    ctl,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [7:0]               out_char,
  output logic                     last
);
  import intfmt_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE = 2'b01,
    E_RUN  = 2'b10
  } estate_t;

  estate_t          state;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] pad_cnt;
  logic [LEN_W-1:0] txt_cnt;
  logic             sign_pend;
  logic             fill_zero;
  logic             left;

  logic [CNT_W-1:0] tot_text, pad_start;
  logic             sel_sign, sel_pad, sel_text;
  logic             load;
  logic [7:0]       ch;

  assign tot_text  = CNT_W'(st.len) + CNT_W'(st.neg);
  assign pad_start = (CNT_W'(st.width) > tot_text) ? CNT_W'(st.width) - tot_text : '0;

  // ordering: zero fill puts sign first, space fill after the pad, left pads last
  always_comb begin
    sel_sign = 1'b0;
    sel_pad  = 1'b0;
    sel_text = 1'b0;
    if (fill_zero) begin
      if (sign_pend)             sel_sign = 1'b1;
      else if (pad_cnt != '0)    sel_pad  = 1'b1;
      else                       sel_text = 1'b1;
    end else if (!left) begin
      if (pad_cnt != '0)         sel_pad  = 1'b1;
      else if (sign_pend)        sel_sign = 1'b1;
      else                       sel_text = 1'b1;
    end else begin
      if (sign_pend)             sel_sign = 1'b1;
      else if (txt_cnt != '0)    sel_text = 1'b1;
      else                       sel_pad  = 1'b1;
    end
    if (sel_sign)      ch = CH_MINUS;
    else if (sel_pad)  ch = fill_zero ? CH_ZERO : CH_SPACE;
    else               ch = st.chr;
  end

  assign load        = (state == E_RUN) && (remain != '0) && (!res_valid || !res_stall);
  assign ctl.advance = load && sel_text;
  assign ctl.finish  = (state == E_RUN) && (remain == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= E_IDLE;
      remain    <= '0;
      pad_cnt   <= '0;
      txt_cnt   <= '0;
      sign_pend <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        E_IDLE: begin
          if (st.done) begin
            remain    <= pad_start + tot_text;
            pad_cnt   <= pad_start;
            txt_cnt   <= st.len;
            sign_pend <= st.neg;
            state     <= E_RUN;
          end
        end
        E_RUN: begin
          if (ctl.finish) begin
            state <= E_IDLE;
          end
          if (load) begin
            remain <= remain - 1'b1;
            if (sel_sign) sign_pend <= 1'b0;
            if (sel_pad)  pad_cnt   <= pad_cnt - 1'b1;
            if (sel_text) txt_cnt   <= txt_cnt - 1'b1;
          end
        end
        default: state <= E_IDLE;
      endcase
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && st.done) begin
      fill_zero <= st.fill_zero;
      left      <= st.left;
    end
    if (load) begin
      out_char <= ch;
      last     <= (remain == CNT_W'(1));
    end
  end

  `INTFMT_ASSERT_IMPL(a_adv_done, clk, rst, ctl.advance, st.done, "text advanced without digits")
  `INTFMT_ASSERT_IMPL(a_fin_drain, clk, rst, ctl.finish, (pad_cnt == '0 && txt_cnt == '0 && !sign_pend), "field closed with characters left")
  `INTFMT_ASSERT_IMPL(a_fin_last, clk, rst, ctl.finish, (!res_valid || last), "field closed without last flag")

endmodule

// ----- rtl/integer_field_formatter_unit.sv -----
`timescale 1ns / 1ps
// Integer field formatter: takes one conversion request (signed/unsigned
// decimal, octal, lower/upper hex, binary or char) and streams the padded
// ASCII field one character per cycle while the output is not stalled,
// last set on the final character. A request is accepted only while the
// unit is idle. Per request the unit takes it, runs the double-dabble loop
// for decimal kinds, skips leading zero digits (at most 9 decimal, 10
// octal, 7 hex, 31 binary) and leaves the skip, starts emission, then
// sends each character (width, or text plus sign if longer) and closes
// the field. Rate is set by the bit-serial binary to BCD loop and the
// single character output register. Type 7 is taken and produces
// nothing; a char of 0 prints padding only.
module integer_field_formatter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] value,
  input  logic [6:0]  min_width,
  input  logic        left_justify,
  input  logic        zero_fill,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  out_char,
  output logic        last
);
  import intfmt_pkg::*;

  conv_status_t st;   // conversion result, held until the field is closed
  emit_ctl_t    ctl;  // digit advance and field close from the emitter
  logic         busy;

  // stall while a request is being converted or emitted
  assign req_stall = busy;

  // value to digits: double dabble for decimal, direct shift for power-of-two
  intfmt_conv u_conv (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_type     (req_type),
    .value        (value),
    .min_width    (min_width),
    .left_justify (left_justify),
    .zero_fill    (zero_fill),
    .busy         (busy),
    .ctl          (ctl),
    .st           (st)
  );

  // sign, padding and text sequencing into the output register
  intfmt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .st        (st),
    .ctl       (ctl),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

// ----- dv/integer_field_formatter_unit_test.sv -----
`timescale 1ns / 1ps
module integer_field_formatter_unit_test;
  import intfmt_pkg::*;

  // req_type 7 is not a conversion: the unit takes the request and emits nothing
  localparam logic [2:0] KIND_NONE = 3'd7;
  // field width saturates here
  localparam int MAX_FIELD = 64;
  // settle time after the last expected character
  localparam int SETTLE_CYCLES = 250;
  // receiver hold-off long enough to back the unit up into its input
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 335;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_SPACE   = 8'h20;
  localparam logic [7:0] ASCII_MINUS   = 8'h2D;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } field_char_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  req_type = 3'd0;
  logic [31:0] value = 32'd0;
  logic [6:0]  min_width = 7'd0;
  logic        left_justify = 1'b0;
  logic        zero_fill = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [7:0]  out_char;
  logic        last;

  // characters still owed by the unit, oldest first
  field_char_t pending_chars[$];
  int          error_count = 0;
  // requests left in the current sender burst; zero starts a new burst, possibly after a gap
  int          burst_left = 0;
  // set by a test to ask the receiver for a long hold-off
  int          hold_request = 0;

  integer_field_formatter_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .value        (value),
    .min_width    (min_width),
    .left_justify (left_justify),
    .zero_fill    (zero_fill),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_char     (out_char),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Builds the padded field for one request and queues its characters.
  // Zero fill: sign, zeros, digits. Space fill: spaces, sign, digits.
  // Left justify: sign, digits, spaces. Char ignores zero fill.
  function automatic void predict_field(input logic [2:0] kind_code, input logic [31:0] val,
                                        input logic [6:0] wid, input logic lj,
                                        input logic zf);
    logic [7:0]  text[$];
    logic [7:0]  field[$];
    logic [31:0] mag;
    logic [31:0] radix;
    logic [31:0] digit;
    logic [7:0]  c;
    logic [7:0]  pad;
    logic        neg;
    int          width_eff;
    int          pad_count;
    field_char_t fc;
    if (kind_code == KIND_NONE) return;
    width_eff = (wid > MAX_FIELD) ? MAX_FIELD : int'(wid);
    neg = 1'b0;
    mag = val;
    pad = (zf && !lj && kind_code != K_CHAR) ? ASCII_ZERO : ASCII_SPACE;
    if (kind_code == K_CHAR) begin
      // a NUL char prints nothing, padding still goes out
      if (val[7:0] != 8'd0) text.push_back(val[7:0]);
    end else begin
      case (kind_code)
        K_SDEC, K_UDEC: radix = 10;
        K_OCT:          radix = 8;
        K_BIN:          radix = 2;
        default:        radix = 16;
      endcase
      if (kind_code == K_SDEC && val[31]) begin
        neg = 1'b1;
        mag = 32'd0 - val;  // most negative value stays 2^31 as unsigned
      end
      // do-while gives a single '0' for zero
      do begin
        digit = mag % radix;
        if (digit < 10) c = ASCII_ZERO + digit[7:0];
        else if (kind_code == K_HEXU) c = ASCII_UPPER_A + digit[7:0] - 8'd10;
        else c = ASCII_LOWER_A + digit[7:0] - 8'd10;
        text.push_front(c);
        mag = mag / radix;
      end while (mag != 0);
    end
    pad_count = (width_eff == 0) ? 0 : width_eff - text.size() - (neg ? 1 : 0);
    if (neg && pad == ASCII_ZERO) field.push_back(ASCII_MINUS);
    if (!lj) for (int i = 0; i < pad_count; i++) field.push_back(pad);
    if (neg && pad == ASCII_SPACE) field.push_back(ASCII_MINUS);
    foreach (text[i]) field.push_back(text[i]);
    if (lj) for (int i = 0; i < pad_count; i++) field.push_back(ASCII_SPACE);
    foreach (field[i]) begin
      fc.chr  = field[i];
      fc.last = (i == field.size() - 1);
      pending_chars.push_back(fc);
    end
  endfunction

  // Offers one request, holding it steady until taken. Bursts of random length
  // with random gaps; valid stays high across back-to-back requests.
  task automatic send_request(input logic [2:0] kind_code, input logic [31:0] val,
                              input logic [6:0] wid, input logic lj, input logic zf);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    req_type     <= kind_code;
    value        <= val;
    min_width    <= wid;
    left_justify <= lj;
    zero_fill    <= zf;
    do @(posedge clk); while (req_stall);
    // taken at this edge; its first character can only show from the next
    predict_field(kind_code, val, wid, lj, zf);
  endtask

  // Drop valid, wait for every owed character, then let the unit settle.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    burst_left = 0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Field extremes, every conversion and each corner named for the unit.
  task automatic test_directed();
    send_request(K_SDEC, 32'h8000_0000, 7'd0,   1'b0, 1'b0);  // most negative
    send_request(K_SDEC, 32'h8000_0000, 7'd15,  1'b0, 1'b1);  // sign before zeros
    send_request(K_SDEC, 32'hFFFF_FFFB, 7'd6,   1'b0, 1'b0);  // sign after spaces
    send_request(K_SDEC, 32'hFFFF_FFFB, 7'd6,   1'b1, 1'b0);  // left, pad right
    send_request(K_SDEC, 32'hFFFF_FFFF, 7'd64,  1'b0, 1'b1);
    send_request(K_SDEC, 32'h7FFF_FFFF, 7'd11,  1'b0, 1'b1);
    send_request(K_SDEC, 32'd12345,     7'd3,   1'b0, 1'b1);  // width under text
    send_request(K_UDEC, 32'hFFFF_FFFF, 7'd0,   1'b0, 1'b0);
    send_request(K_UDEC, 32'd0,         7'd0,   1'b0, 1'b0);  // zero prints '0'
    send_request(K_UDEC, 32'h8000_0000, 7'd100, 1'b1, 1'b1);  // saturated, left
    send_request(K_OCT,  32'hFFFF_FFFF, 7'd0,   1'b0, 1'b0);
    send_request(K_OCT,  32'd0,         7'd1,   1'b0, 1'b1);
    send_request(K_HEXL, 32'hDEAD_BEEF, 7'd12,  1'b0, 1'b1);
    send_request(K_HEXU, 32'hDEAD_BEEF, 7'd12,  1'b1, 1'b1);  // zero fill ignored
    send_request(K_HEXL, 32'd0,         7'd127, 1'b0, 1'b1);  // oversized width
    send_request(K_BIN,  32'hFFFF_FFFF, 7'd64,  1'b0, 1'b0);
    send_request(K_BIN,  32'd1,         7'd64,  1'b0, 1'b1);
    send_request(K_CHAR, 32'd65,        7'd5,   1'b0, 1'b1);  // zero fill ignored
    send_request(K_CHAR, 32'hABCD_EF7F, 7'd1,   1'b1, 1'b0);  // low byte only
    send_request(K_CHAR, 32'hFFFF_FF00, 7'd0,   1'b0, 1'b0);  // NUL, no output
    send_request(K_CHAR, 32'd0,         7'd3,   1'b1, 1'b0);  // NUL, padding only
    send_request(KIND_NONE, 32'hFFFF_FFFF, 7'd127, 1'b1, 1'b1);  // unknown, ignored
    wait_for_drain();
  endtask

  // Receiver holds off for a long stretch while wide requests keep coming,
  // so the unit backs up and stalls its input.
  task automatic test_input_backpressure();
    hold_request = LONG_HOLD_CYCLES;
    burst_left = 8;
    for (int i = 0; i < 8; i++) begin
      send_request(logic'(i[0]) ? K_UDEC : K_SDEC, $urandom, 7'($urandom_range(20, 64)),
                   1'($urandom), 1'($urandom));
    end
  endtask

  // Sender stops until every owed character has come, then carries on.
  task automatic test_drain_pause();
    for (int i = 0; i < 4; i++) begin
      send_request(3'($urandom_range(0, 6)), $urandom, 7'($urandom_range(0, 16)),
                   1'($urandom), 1'($urandom));
    end
    wait_for_drain();
    send_request(K_HEXU, $urandom, 7'd9, 1'b0, 1'b1);
  endtask

  // Random requests: mostly narrow fields, a few wide ones; value shapes
  // chosen to hit zeros, powers of two, small negatives and short magnitudes.
  task automatic test_random();
    logic [2:0]  kind_code;
    logic [31:0] val;
    logic [6:0]  wid;
    int          taken;
    taken = 0;
    while (taken < RANDOM_REQUESTS) begin
      kind_code = ($urandom_range(0, 39) == 0) ? KIND_NONE : 3'($urandom_range(0, 6));
      case ($urandom_range(0, 4))
        0: val = $urandom;
        1: val = $urandom_range(0, 20);
        2: val = 32'd1 << $urandom_range(0, 31);
        3: val = 32'd0 - $urandom_range(1, 1000);
        default: val = $urandom >> $urandom_range(0, 31);
      endcase
      wid = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(25, 127))
                                        : 7'($urandom_range(0, 24));
      send_request(kind_code, val, wid, 1'($urandom), 1'($urandom));
      // the unit merely ignores type 7, so it does not count
      if (kind_code != KIND_NONE) taken++;
    end
  endtask

  // Receiver: random stall modes in segments, including stretches with none;
  // a long hold-off when a test asks, counted down here.
  initial begin : result_sink
    int seg_left;
    int mode;
    int hold_left;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 4);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        case (mode)
          0: res_stall <= 1'b0;
          1: res_stall <= ($urandom_range(0, 9) < 3);
          2: res_stall <= ($urandom_range(0, 9) < 7);
          3: res_stall <= ~res_stall;
          default: res_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Each character taken is checked against the oldest one owed.
  always @(posedge clk) begin : result_check
    field_char_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected character", {24'd0, out_char}, 32'd0);
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.chr)
          report_mismatch("out_char", {24'd0, out_char}, {24'd0, want.chr});
        if (last !== want.last) report_mismatch("last", {31'd0, last}, {31'd0, want.last});
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_input_backpressure();
    test_drain_pause();
    test_random();
    wait_for_drain();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop: ends a run that hangs with a failure.
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
